// ===== hw/rtl/sdspi_pkg.sv =====
// Types and constants shared by the SD card SPI sector controller.
// No dependencies.
package sdspi_pkg;

    typedef enum logic [1:0] {
        FN_REQUEST = 2'd0,
        FN_XFER    = 2'd1,
        FN_DETECT  = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    localparam logic [1:0] RQ_INIT  = 2'd0;
    localparam logic [1:0] RQ_READ  = 2'd1;
    localparam logic [1:0] RQ_WRITE = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE, PH_CLOCKS, PH_CMD, PH_R1, PH_TAIL, PH_R32, PH_CID_SYNC,
        PH_CID_DATA, PH_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_WR_PRE, PH_WR_DATA,
        PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY, PH_R2
    } t_phase;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_NOTREADY = 4'd1;
    localparam logic [3:0] ST_RSTFAIL  = 4'd2;
    localparam logic [3:0] ST_BAD_R1   = 4'd3;
    localparam logic [3:0] ST_BAD_R7   = 4'd4;
    localparam logic [3:0] ST_BAD_OCR  = 4'd5;
    localparam logic [3:0] ST_BAD_TOK  = 4'd6;
    localparam logic [3:0] ST_REJECT   = 4'd7;
    localparam logic [3:0] ST_BUSY_TO  = 4'd8;
    localparam logic [3:0] ST_BAD_R2   = 4'd9;
    localparam logic [3:0] ST_BUSY     = 4'd10;

    localparam logic [5:0] CMD0  = 6'd0;
    localparam logic [5:0] CMD8  = 6'd8;
    localparam logic [5:0] CMD10 = 6'd10;
    localparam logic [5:0] CMD13 = 6'd13;
    localparam logic [5:0] CMD17 = 6'd17;
    localparam logic [5:0] CMD24 = 6'd24;
    localparam logic [5:0] CMD41 = 6'd41;
    localparam logic [5:0] CMD55 = 6'd55;
    localparam logic [5:0] CMD58 = 6'd58;

    localparam logic [2:0] CFG_RESET_RETRY = 3'd0;
    localparam logic [2:0] CFG_OPCOND_V2   = 3'd1;
    localparam logic [2:0] CFG_OPCOND_V1   = 3'd2;
    localparam logic [2:0] CFG_RESP_POLL   = 3'd3;
    localparam logic [2:0] CFG_TOKEN_POLL  = 3'd4;
    localparam logic [2:0] CFG_BUSY_POLL   = 3'd5;

    localparam int CFG_W = 17;
    localparam logic [16:0] IDLE_BYTES     = 17'd10;
    localparam logic [16:0] SECTOR_BYTES   = 17'd512;
    localparam logic [16:0] CID_BYTES      = 17'd20;
    localparam logic [16:0] CID_SYNC_LIMIT = 17'd100;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  request;
        logic [31:0] sector;
        logic [7:0]  rx_byte;
        logic [7:0]  wr_byte;
        logic        card_present;
    } t_in;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_card;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       wr_taken;
        logic       done_res;
        logic [3:0] status;
        logic       card_ready;
        logic       card_standard;
    } t_out;

    typedef struct packed {
        logic [7:0]  reset_retry;
        logic [15:0] opcond_v2;
        logic [15:0] opcond_v1;
        logic [7:0]  resp_poll;
        logic [15:0] token_poll;
        logic [16:0] busy_poll;
    } t_cfg;

endpackage

// ===== hw/rtl/sdspi_cfg.sv =====
// Configuration register file of the SD card SPI sector controller.
// Depends on sdspi_pkg.
module sdspi_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [sdspi_pkg::CFG_W-1:0] i_cfg_data,
    output sdspi_pkg::t_cfg            o_cfg
);
    sdspi_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_retry <= 8'd10;
            r_cfg.opcond_v2   <= 16'd1000;
            r_cfg.opcond_v1   <= 16'd10;
            r_cfg.resp_poll   <= 8'd8;
            r_cfg.token_poll  <= 16'd1023;
            r_cfg.busy_poll   <= 17'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdspi_pkg::CFG_RESET_RETRY: r_cfg.reset_retry <= i_cfg_data[7:0];
                sdspi_pkg::CFG_OPCOND_V2:   r_cfg.opcond_v2   <= i_cfg_data[15:0];
                sdspi_pkg::CFG_OPCOND_V1:   r_cfg.opcond_v1   <= i_cfg_data[15:0];
                sdspi_pkg::CFG_RESP_POLL:   r_cfg.resp_poll   <= i_cfg_data[7:0];
                sdspi_pkg::CFG_TOKEN_POLL:  r_cfg.token_poll  <= i_cfg_data[15:0];
                sdspi_pkg::CFG_BUSY_POLL:   r_cfg.busy_poll   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== hw/rtl/sdspi_seq.sv =====
// Sequencer state and per-request next-state logic.
// Depends on sdspi_pkg.
module sdspi_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  sdspi_pkg::t_in  i_item,
    input  sdspi_pkg::t_cfg i_cfg,
    output sdspi_pkg::t_out o_res
);
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_EMIT   = 3'd1;
    localparam logic [2:0] ACT_GO     = 3'd2;
    localparam logic [2:0] ACT_FINISH = 3'd3;
    localparam logic [2:0] ACT_CMD    = 3'd4;

    sdspi_pkg::t_phase r_phase, n_phase;
    logic [16:0] r_cnt, n_cnt, cnt1;
    logic [15:0] r_retry, n_retry;
    logic [31:0] r_shift, n_shift, r_arg, n_arg;
    logic [5:0]  r_cmd, n_cmd;
    logic [7:0]  r_crc, n_crc;
    logic r_ready, n_ready, r_std, n_std, r_last, n_last;
    logic r_cs, n_cs, r_v1, n_v1, r_ocr, n_ocr;
    sdspi_pkg::t_out res;
    logic [7:0] rx;
    logic [16:0] rlim, tlim, blim;
    logic [15:0] olim;
    logic [31:0] m;
    logic [2:0] act;
    sdspi_pkg::t_phase go_ph;
    logic [3:0] fst;
    logic [5:0] sc;
    logic [31:0] sa;
    logic [7:0] scrc;

    assign cnt1 = r_cnt + 17'd1;
    assign rx = i_item.rx_byte;
    assign rlim = (i_cfg.resp_poll == 8'd0) ? 17'd1 : {9'd0, i_cfg.resp_poll};
    assign tlim = (i_cfg.token_poll == 16'd0) ? 17'd1 : {1'b0, i_cfg.token_poll};
    assign blim = (i_cfg.busy_poll == 17'd0) ? 17'd1 : i_cfg.busy_poll;
    assign olim = r_v1 ? i_cfg.opcond_v1 : i_cfg.opcond_v2;
    assign m = r_shift & 32'hc0300000;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_retry = r_retry; n_shift = r_shift;
        n_arg = r_arg; n_cmd = r_cmd; n_crc = r_crc; n_ready = r_ready;
        n_std = r_std; n_last = r_last; n_cs = r_cs; n_v1 = r_v1; n_ocr = r_ocr;
        res = '0;
        act = ACT_NONE; go_ph = sdspi_pkg::PH_IDLE; fst = '0;
        sc = '0; sa = '0; scrc = 8'hff;

        // Each exchange step picks one action, applied after the phase case.
        case (sdspi_pkg::t_func'(i_item.func))
            sdspi_pkg::FN_REQUEST: begin
                if (r_phase != sdspi_pkg::PH_IDLE) begin
                    res.status = sdspi_pkg::ST_BUSY;
                end else if (i_item.request == sdspi_pkg::RQ_INIT) begin
                    n_ready = 1'b0; n_v1 = 1'b0; n_ocr = 1'b0; n_retry = '0;
                    n_cs = 1'b0; n_phase = sdspi_pkg::PH_CLOCKS; n_cnt = '0;
                    res.tx_valid = 1'b1; res.tx_byte = 8'hff;
                end else if (i_item.request == sdspi_pkg::RQ_READ ||
                             i_item.request == sdspi_pkg::RQ_WRITE) begin
                    if (!r_ready) begin
                        res.done_res = 1'b1; res.status = sdspi_pkg::ST_NOTREADY;
                    end else begin
                        n_cmd = (i_item.request == sdspi_pkg::RQ_READ) ?
                                sdspi_pkg::CMD17 : sdspi_pkg::CMD24;
                        n_arg = r_std ? {i_item.sector[22:0], 9'd0} : i_item.sector;
                        n_crc = 8'hff; n_cs = 1'b1; n_phase = sdspi_pkg::PH_CMD;
                        n_cnt = '0; res.tx_valid = 1'b1;
                        res.tx_byte = {2'b01, n_cmd};
                    end
                end
            end
            sdspi_pkg::FN_DETECT: begin
                if (!i_item.card_present && r_last) n_ready = 1'b0;
                if (i_item.card_present && !r_last &&
                    r_phase == sdspi_pkg::PH_IDLE) begin
                    n_ready = 1'b0; n_v1 = 1'b0; n_ocr = 1'b0; n_retry = '0;
                    n_cs = 1'b0; n_phase = sdspi_pkg::PH_CLOCKS; n_cnt = '0;
                    res.tx_valid = 1'b1; res.tx_byte = 8'hff;
                end
                n_last = i_item.card_present;
            end
            sdspi_pkg::FN_XFER: begin
                case (r_phase)
                    sdspi_pkg::PH_CLOCKS: begin
                        n_cnt = cnt1;
                        if (cnt1 < sdspi_pkg::IDLE_BYTES) act = ACT_EMIT;
                        else begin act = ACT_CMD; sc = sdspi_pkg::CMD0; scrc = 8'h95; end
                    end
                    sdspi_pkg::PH_CMD: begin
                        n_cnt = cnt1;
                        if (cnt1 < 17'd6) begin
                            res.tx_valid = 1'b1;
                            case (cnt1[2:0])
                                3'd1: res.tx_byte = r_arg[31:24];
                                3'd2: res.tx_byte = r_arg[23:16];
                                3'd3: res.tx_byte = r_arg[15:8];
                                3'd4: res.tx_byte = r_arg[7:0];
                                default: res.tx_byte = r_crc;
                            endcase
                        end else begin act = ACT_GO; go_ph = sdspi_pkg::PH_R1; end
                    end
                    sdspi_pkg::PH_R1: begin
                        n_cnt = cnt1;
                        if (rx != 8'hff || cnt1 >= rlim) begin
                            case (r_cmd)
                                sdspi_pkg::CMD0, sdspi_pkg::CMD55, sdspi_pkg::CMD41: begin
                                    n_shift = {24'd0, rx}; n_cs = 1'b0;
                                    act = ACT_GO; go_ph = sdspi_pkg::PH_TAIL;
                                end
                                sdspi_pkg::CMD8: begin
                                    if (rx == 8'h01) begin
                                        n_shift = '0; act = ACT_GO;
                                        go_ph = sdspi_pkg::PH_R32;
                                    end else if (rx == 8'h05) begin
                                        n_v1 = 1'b1; act = ACT_CMD; sc = sdspi_pkg::CMD58;
                                    end else begin
                                        act = ACT_FINISH; fst = sdspi_pkg::ST_BAD_R1;
                                    end
                                end
                                default: begin
                                    if (rx != 8'h00) begin
                                        act = ACT_FINISH; fst = sdspi_pkg::ST_BAD_R1;
                                    end else begin
                                        act = ACT_GO;
                                        case (r_cmd)
                                            sdspi_pkg::CMD58: begin
                                                n_shift = '0; go_ph = sdspi_pkg::PH_R32;
                                            end
                                            sdspi_pkg::CMD10: go_ph = sdspi_pkg::PH_CID_SYNC;
                                            sdspi_pkg::CMD17: go_ph = sdspi_pkg::PH_TOKEN;
                                            sdspi_pkg::CMD24: go_ph = sdspi_pkg::PH_WR_PRE;
                                            default: go_ph = sdspi_pkg::PH_R2;
                                        endcase
                                    end
                                end
                            endcase
                        end else act = ACT_EMIT;
                    end
                    sdspi_pkg::PH_TAIL: begin
                        case (r_cmd)
                            sdspi_pkg::CMD0: begin
                                if (r_shift[7:0] == 8'h01) begin
                                    act = ACT_CMD; sc = sdspi_pkg::CMD8;
                                    sa = 32'h000001aa; scrc = 8'h87;
                                end else if (r_retry >= {8'd0, i_cfg.reset_retry}) begin
                                    act = ACT_FINISH; fst = sdspi_pkg::ST_RSTFAIL;
                                end else begin
                                    n_retry = r_retry + 16'd1; n_cs = 1'b0;
                                    act = ACT_GO; go_ph = sdspi_pkg::PH_CLOCKS;
                                end
                            end
                            sdspi_pkg::CMD8: begin
                                if (r_shift[15:0] != 16'h01aa) begin
                                    act = ACT_FINISH; fst = sdspi_pkg::ST_BAD_R7;
                                end else begin
                                    n_retry = '0; act = ACT_CMD; sc = sdspi_pkg::CMD55;
                                end
                            end
                            sdspi_pkg::CMD55: begin
                                if (r_shift[7:0] != 8'h01) begin
                                    act = ACT_FINISH; fst = sdspi_pkg::ST_BAD_R1;
                                end else begin
                                    act = ACT_CMD; sc = sdspi_pkg::CMD41; sa = 32'h40000000;
                                end
                            end
                            sdspi_pkg::CMD41: begin
                                if (r_shift[7:0] == 8'h00) begin
                                    if (r_v1) begin
                                        n_std = 1'b1; n_ready = 1'b1;
                                        act = ACT_FINISH; fst = sdspi_pkg::ST_OK;
                                    end else begin act = ACT_CMD; sc = sdspi_pkg::CMD58; end
                                end else if (r_retry >= olim) begin
                                    act = ACT_FINISH; fst = sdspi_pkg::ST_BAD_R1;
                                end else begin
                                    n_retry = r_retry + 16'd1; act = ACT_CMD;
                                    if (r_v1) begin
                                        sc = sdspi_pkg::CMD41; sa = 32'h40000000;
                                    end else sc = sdspi_pkg::CMD55;
                                end
                            end
                            sdspi_pkg::CMD58: begin
                                if (r_v1) begin
                                    if (r_shift != 32'he0ff8000) begin
                                        act = ACT_FINISH; fst = sdspi_pkg::ST_BAD_OCR;
                                    end else begin
                                        n_retry = '0; act = ACT_CMD;
                                        sc = sdspi_pkg::CMD41; sa = 32'h40000000;
                                    end
                                end else begin
                                    n_ocr = m[31] && (m[21:20] != 2'b00);
                                    if (m[31] && (m[21:20] != 2'b00)) n_std = !m[30];
                                    act = ACT_CMD; sc = sdspi_pkg::CMD10;
                                end
                            end
                            default: begin act = ACT_FINISH; fst = sdspi_pkg::ST_OK; end
                        endcase
                    end
                    sdspi_pkg::PH_R32: begin
                        n_shift = {r_shift[23:0], rx}; n_cnt = cnt1;
                        if (cnt1 < 17'd4) act = ACT_EMIT;
                        else begin
                            n_cs = 1'b0; act = ACT_GO; go_ph = sdspi_pkg::PH_TAIL;
                        end
                    end
                    sdspi_pkg::PH_CID_SYNC, sdspi_pkg::PH_CID_DATA: begin
                        n_cnt = cnt1;
                        if (r_phase == sdspi_pkg::PH_CID_SYNC && rx == 8'hfe) begin
                            act = ACT_GO; go_ph = sdspi_pkg::PH_CID_DATA;
                        end else if ((r_phase == sdspi_pkg::PH_CID_SYNC &&
                                      cnt1 >= sdspi_pkg::CID_SYNC_LIMIT) ||
                                     (r_phase == sdspi_pkg::PH_CID_DATA &&
                                      cnt1 >= sdspi_pkg::CID_BYTES)) begin
                            act = ACT_FINISH;
                            if (r_ocr) begin n_ready = 1'b1; fst = sdspi_pkg::ST_OK; end
                            else fst = sdspi_pkg::ST_BAD_OCR;
                        end else act = ACT_EMIT;
                    end
                    sdspi_pkg::PH_TOKEN: begin
                        n_cnt = cnt1;
                        if (rx != 8'hff || cnt1 >= tlim) begin
                            if (rx == 8'hfe) begin
                                act = ACT_GO; go_ph = sdspi_pkg::PH_RD_DATA;
                            end else begin
                                act = ACT_FINISH; fst = sdspi_pkg::ST_BAD_TOK;
                            end
                        end else act = ACT_EMIT;
                    end
                    sdspi_pkg::PH_RD_DATA: begin
                        res.rd_valid = 1'b1; res.rd_byte = rx; n_cnt = cnt1;
                        if (cnt1 < sdspi_pkg::SECTOR_BYTES) act = ACT_EMIT;
                        else begin act = ACT_GO; go_ph = sdspi_pkg::PH_RD_CRC; end
                    end
                    sdspi_pkg::PH_RD_CRC: begin
                        n_cnt = cnt1;
                        if (cnt1 < 17'd2) act = ACT_EMIT;
                        else begin
                            n_cs = 1'b0; act = ACT_GO; go_ph = sdspi_pkg::PH_TAIL;
                        end
                    end
                    sdspi_pkg::PH_WR_PRE: begin
                        n_cnt = cnt1; res.tx_valid = 1'b1;
                        if (cnt1 < 17'd2) res.tx_byte = 8'hfe;
                        else begin
                            n_phase = sdspi_pkg::PH_WR_DATA; n_cnt = '0;
                            res.tx_byte = i_item.wr_byte; res.wr_taken = 1'b1;
                        end
                    end
                    sdspi_pkg::PH_WR_DATA: begin
                        n_cnt = cnt1;
                        if (cnt1 < sdspi_pkg::SECTOR_BYTES) begin
                            res.tx_valid = 1'b1; res.tx_byte = i_item.wr_byte;
                            res.wr_taken = 1'b1;
                        end else begin act = ACT_GO; go_ph = sdspi_pkg::PH_WR_CRC; end
                    end
                    sdspi_pkg::PH_WR_CRC: begin
                        n_cnt = cnt1;
                        if (cnt1 < 17'd2) act = ACT_EMIT;
                        else begin act = ACT_GO; go_ph = sdspi_pkg::PH_WR_RESP; end
                    end
                    sdspi_pkg::PH_WR_RESP: begin
                        if (rx[4:0] != 5'h05) begin
                            act = ACT_FINISH; fst = sdspi_pkg::ST_REJECT;
                        end else begin act = ACT_GO; go_ph = sdspi_pkg::PH_WR_BUSY; end
                    end
                    sdspi_pkg::PH_WR_BUSY: begin
                        n_cnt = cnt1;
                        if (rx != 8'h00) begin act = ACT_CMD; sc = sdspi_pkg::CMD13; end
                        else if (cnt1 >= blim) begin
                            act = ACT_FINISH; fst = sdspi_pkg::ST_BUSY_TO;
                        end else act = ACT_EMIT;
                    end
                    sdspi_pkg::PH_R2: begin
                        if (rx != 8'h00) begin
                            act = ACT_FINISH; fst = sdspi_pkg::ST_BAD_R2;
                        end else begin act = ACT_GO; go_ph = sdspi_pkg::PH_TAIL; end
                    end
                    default: ;
                endcase
                case (act)
                    ACT_EMIT: begin res.tx_valid = 1'b1; res.tx_byte = 8'hff; end
                    ACT_GO: begin
                        n_phase = go_ph; n_cnt = '0;
                        res.tx_valid = 1'b1; res.tx_byte = 8'hff;
                    end
                    ACT_FINISH: begin
                        n_cs = 1'b0; n_phase = sdspi_pkg::PH_IDLE; n_cnt = '0;
                        res.done_res = 1'b1; res.status = fst;
                    end
                    ACT_CMD: begin
                        n_cmd = sc; n_arg = sa; n_crc = scrc; n_cs = 1'b1;
                        n_phase = sdspi_pkg::PH_CMD; n_cnt = '0;
                        res.tx_valid = 1'b1; res.tx_byte = {2'b01, sc};
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.select_card = n_cs;
        res.card_ready = n_ready;
        res.card_standard = n_std;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdspi_pkg::PH_IDLE; r_cnt <= '0; r_retry <= '0;
            r_shift <= '0; r_arg <= '0; r_cmd <= '0; r_crc <= '0;
            r_ready <= 1'b0; r_std <= 1'b0; r_last <= 1'b0;
            r_cs <= 1'b0; r_v1 <= 1'b0; r_ocr <= 1'b0;
        end else if (i_go) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_retry <= n_retry;
            r_shift <= n_shift; r_arg <= n_arg; r_cmd <= n_cmd; r_crc <= n_crc;
            r_ready <= n_ready; r_std <= n_std; r_last <= n_last;
            r_cs <= n_cs; r_v1 <= n_v1; r_ocr <= n_ocr;
        end
    end

    assign o_res = res;
endmodule

// ===== hw/rtl/sd_card_spi_sector_controller.sv =====
// Top level of the SD card SPI-mode sector controller.
// Depends on sdspi_pkg, sdspi_cfg and sdspi_seq.
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  --------------------
//  request   in   i_in_valid / o_in_stall   i_in  (t_in)
//  result    out  o_out_valid / i_out_stall o_out (t_out)
//  config    in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One request in, one result out. The sequencer update is registered: a
// request is taken at an edge and its result sits in the output register
// from the next cycle, so a request can be taken in every cycle while the
// result side keeps up. A stalled result holds; the input stalls only when
// the output register is full and stalled. Reset (synchronous, active low)
// returns the sequencer to idle and the config registers to defaults.
module sd_card_spi_sector_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  sdspi_pkg::t_in              i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output sdspi_pkg::t_out             o_out,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [sdspi_pkg::CFG_W-1:0] i_cfg_data
);
    sdspi_pkg::t_cfg cfg;
    sdspi_pkg::t_out res;
    sdspi_pkg::t_out r_out;
    logic r_out_valid;
    logic go;

    // Take a request when the output slot is free or being emptied.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign go = i_in_valid && !o_in_stall;

    sdspi_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    sdspi_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go),
        .i_item(i_in), .i_cfg(cfg), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= go;
        end
    end

    // Load the result register with each taken request.
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;
endmodule

// ===== hw/rtl/sdspi_chk.sv =====
// Port-level checker for the SD card SPI sector controller, with its bind.
// Depends on sdspi_pkg.
module sdspi_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input sdspi_pkg::t_out o_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("taken request gave no result");

    a_rd_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.rd_valid |-> !o_out.done_res)
        else $error("read data together with completion");

    a_fail_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |-> !o_out.select_card && !o_out.tx_valid)
        else $error("completion kept chip select");
endmodule

bind sd_card_spi_sector_controller sdspi_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out(o_out)
);
